// File: hdl/nbg_pkg.sv
// Shared types, codes and defaults for the n-body gravity substep block.
// No dependencies; nbg_datapath, nbg_ctrl and nbody_gravity_substep import this package.
package nbg_pkg;

   localparam int DEFAULT_MAX_BODIES    = 32;
   localparam int DEFAULT_FRACTION_BITS = 16;

   // request kinds carried on req_tuser
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   // register indexes on the csr port
   localparam logic [1:0] CSR_GRAVITY    = 2'd0;
   localparam logic [1:0] CSR_SUBSTEPS   = 2'd1;
   localparam logic [1:0] CSR_BODY_COUNT = 2'd2;

   localparam logic [31:0] GRAVITY_RESET    = 32'h0001_0000;
   localparam logic [4:0]  SUBSTEPS_RESET   = 5'd1;
   localparam logic [5:0]  BODY_COUNT_RESET = 6'd1;
   localparam logic [4:0]  SUBSTEPS_MAX     = 5'd16;

   // datapath operations issued by the controller
   localparam logic [4:0] OP_NONE       = 5'd0;
   localparam logic [4:0] OP_LOAD       = 5'd1;
   localparam logic [4:0] OP_DT_START   = 5'd2;
   localparam logic [4:0] OP_DT_TAKE    = 5'd3;
   localparam logic [4:0] OP_LATCH_I    = 5'd4;
   localparam logic [4:0] OP_LATCH_J    = 5'd5;
   localparam logic [4:0] OP_SQ         = 5'd6;
   localparam logic [4:0] OP_GM         = 5'd7;
   localparam logic [4:0] OP_ROOT_START = 5'd8;
   localparam logic [4:0] OP_A_START    = 5'd9;
   localparam logic [4:0] OP_A_TAKE     = 5'd10;
   localparam logic [4:0] OP_U_START    = 5'd11;
   localparam logic [4:0] OP_U_TAKE     = 5'd12;
   localparam logic [4:0] OP_AC         = 5'd13;
   localparam logic [4:0] OP_DV         = 5'd14;
   localparam logic [4:0] OP_WB_VEL     = 5'd15;
   localparam logic [4:0] OP_VDT        = 5'd16;
   localparam logic [4:0] OP_MOVE       = 5'd17;
   localparam logic [4:0] OP_WB_POS     = 5'd18;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] axis;
   } nbg_cmd_type;

   typedef struct packed {
      logic div_done;
      logic root_done;
      logic ft_small;
      logic coincident;
   } nbg_status_type;

endpackage

// File: hdl/nbg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nbg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/nbg_datapath.sv
// Datapath: body stores, shared multiplier, shared divider and square root unit.
// Depends on nbg_pkg and nbg_ram; driven by nbg_ctrl through nbg_cmd_type.
module nbg_datapath
   import nbg_pkg::*;
#(
   parameter int MAX_BODIES    = DEFAULT_MAX_BODIES,
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS,
   parameter int IW            = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  nbg_cmd_type    cmd,
   input  logic [IW-1:0]  addr,
   output nbg_status_type status,
   input  logic [31:0]    gravity,
   input  logic [4:0]     s_eff,
   input  logic [4:0]     req_body_index,
   input  logic [95:0]    req_pos,
   input  logic [95:0]    req_vel,
   input  logic [31:0]    req_mass,
   input  logic [31:0]    req_frame_time,
   output logic [4:0]     out_index,
   output logic [95:0]    out_pos
);

   localparam int F   = FRACTION_BITS;
   localparam int PW  = 64 - F;
   localparam int SW  = PW + 2;
   localparam int R2W = PW + 2;
   localparam int SMALL_RAW = ((1 << F) + 5000) / 10000;
   localparam logic [31:0] SMALL_TIME = (SMALL_RAW == 0) ? 32'd1 : 32'(SMALL_RAW);
   localparam logic [F:0]     ONE_U  = {1'b1, {F{1'b0}}};
   localparam logic [R2W-1:0] ONE_R2 = {{(R2W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
   localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN = 32'h8000_0000;
   localparam logic [30:0] A_MAX   = 31'h7FFF_FFFF;

   function automatic logic [31:0] abs_d(input logic [32:0] d);
      logic [32:0] t;
      t = d[32] ? (~d + 33'd1) : d;
      return t[31:0];
   endfunction

   function automatic logic [31:0] abs_v(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // add a signed magnitude to a Q word, clip to signed 32 bits
   function automatic logic [31:0] sat_add(input logic [31:0] base,
                                           input logic [PW-1:0] mag_v,
                                           input logic neg);
      logic signed [SW-1:0] b;
      logic signed [SW-1:0] m;
      logic signed [SW-1:0] s;
      b = SW'($signed(base));
      m = $signed({2'b00, mag_v});
      s = neg ? (b - m) : (b + m);
      if (s[SW-1:31] == '0 || s[SW-1:31] == '1) begin
         return s[31:0];
      end
      return s[SW-1] ? S32_MIN : S32_MAX;
   endfunction

   // body stores
   logic [2:0][31:0] pos_rd, vel_rd;
   logic [31:0]      mass_rd;
   logic             k_ok, is_load;
   logic [IW-1:0]    k_addr;
   logic             pos_we, vel_we;
   logic [IW-1:0]    pos_wa, vel_wa;
   logic [95:0]      pos_wd, vel_wd;

   // working registers
   logic [2:0][31:0] p_ff, p_in;
   logic [2:0][31:0] v_ff, v_in;
   logic [2:0][32:0] d_ff, d_in;
   logic [31:0]      mj_ff, mj_in;
   logic [4:0]       idx_ff, idx_in;
   logic [31:0]      dt_ff, dt_in;
   logic [R2W-1:0]   r2_ff, r2_in;
   logic [63:0]      gm_ff, gm_in;
   logic [32:0]      r_ff, r_in;
   logic [30:0]      a_ff, a_in;
   logic [63:0]      mul_p_ff;
   logic [31:0]      mul_a, mul_b;
   logic [PW-1:0]    psh;

   // divider
   logic        dv_busy_ff;
   logic [6:0]  dv_cnt_ff;
   logic [63:0] dv_q_ff, dv_rem_ff, dv_den_ff;
   logic        dv_start;
   logic [63:0] dv_num, dv_den;
   logic [64:0] dv_sh;

   // square root
   logic        rt_busy_ff, rt_dbl_ff;
   logic [4:0]  rt_cnt_ff;
   logic [63:0] rt_v_ff, rt_r_ff, rt_bit_ff;
   logic [63:0] rt_sum, rt_in;
   logic        r2_hi;
   logic [R2W+F-1:0] r2_sh_f, r2_sh_f2;
   logic [32:0] r_raw;
   logic [R2W-1:0] dc;
   logic [F:0]  u_val;
   logic [31:0] ax_dmag;
   logic [31:0] ax_vmag;

   assign is_load = (cmd.op == OP_LOAD);
   assign k_ok    = 32'(req_body_index) < MAX_BODIES;
   assign k_addr  = IW'(req_body_index);

   assign pos_we = (is_load && k_ok) || (cmd.op == OP_WB_POS);
   assign pos_wa = is_load ? k_addr : addr;
   assign pos_wd = is_load ? req_pos : p_ff;
   assign vel_we = (is_load && k_ok) || (cmd.op == OP_WB_VEL);
   assign vel_wa = is_load ? k_addr : addr;
   assign vel_wd = is_load ? req_vel : v_ff;

   nbg_ram #(.WIDTH(96), .DEPTH(MAX_BODIES), .AW(IW)) u_pos_ram (
      .clock(clock), .we(pos_we), .waddr(pos_wa), .wdata(pos_wd),
      .raddr(addr), .rdata(pos_rd)
   );
   nbg_ram #(.WIDTH(96), .DEPTH(MAX_BODIES), .AW(IW)) u_vel_ram (
      .clock(clock), .we(vel_we), .waddr(vel_wa), .wdata(vel_wd),
      .raddr(addr), .rdata(vel_rd)
   );
   nbg_ram #(.WIDTH(32), .DEPTH(MAX_BODIES), .AW(IW)) u_mass_ram (
      .clock(clock), .we(is_load && k_ok), .waddr(k_addr), .wdata(req_mass),
      .raddr(addr), .rdata(mass_rd)
   );

   assign psh     = mul_p_ff[63:F];
   assign ax_dmag = abs_d(d_ff[cmd.axis]);
   assign ax_vmag = abs_v(v_ff[cmd.axis]);

   assign r2_hi    = (r2_ff[R2W-1:PW] != '0);
   assign r2_sh_f  = {r2_ff, {F{1'b0}}};
   assign r2_sh_f2 = {2'b00, r2_ff, {(F-2){1'b0}}};
   assign rt_in    = r2_hi ? r2_sh_f2[63:0] : r2_sh_f[63:0];
   assign r_raw    = rt_dbl_ff ? {rt_r_ff[31:0], 1'b0} : {1'b0, rt_r_ff[31:0]};
   assign dc       = (r2_ff < ONE_R2) ? ONE_R2 : r2_ff;
   assign u_val    = (dv_q_ff > 64'(ONE_U)) ? ONE_U : dv_q_ff[F:0];

   // multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_SQ: begin
            mul_a = ax_dmag;
            mul_b = ax_dmag;
         end
         OP_GM: begin
            mul_a = gravity;
            mul_b = mj_ff;
         end
         OP_U_TAKE: begin
            mul_a = 32'(a_ff);
            mul_b = 32'(u_val);
         end
         OP_AC: begin
            mul_a = mul_p_ff[F +: 32];
            mul_b = dt_ff;
         end
         OP_VDT: begin
            mul_a = ax_vmag;
            mul_b = dt_ff;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // divider operands
   always_comb begin
      dv_start = 1'b0;
      dv_num   = '0;
      dv_den   = '0;
      case (cmd.op)
         OP_DT_START: begin
            dv_start = 1'b1;
            dv_num   = 64'(req_frame_time);
            dv_den   = 64'(s_eff);
         end
         OP_A_START: begin
            dv_start = 1'b1;
            dv_num   = gm_ff;
            dv_den   = 64'(dc);
         end
         OP_U_START: begin
            dv_start = 1'b1;
            dv_num   = 64'({ax_dmag, {F{1'b0}}});
            dv_den   = 64'(r_ff);
         end
         default: begin
            dv_start = 1'b0;
         end
      endcase
   end

   // working register updates
   always_comb begin
      p_in   = p_ff;
      v_in   = v_ff;
      d_in   = d_ff;
      mj_in  = mj_ff;
      idx_in = idx_ff;
      dt_in  = dt_ff;
      r2_in  = r2_ff;
      gm_in  = gm_ff;
      r_in   = r_ff;
      a_in   = a_ff;
      case (cmd.op)
         OP_DT_TAKE: dt_in = dv_q_ff[31:0];
         OP_LATCH_I: begin
            p_in   = pos_rd;
            v_in   = vel_rd;
            idx_in = 5'(addr);
         end
         OP_LATCH_J: begin
            for (int a = 0; a < 3; a++) begin
               d_in[a] = 33'($signed(pos_rd[a])) - 33'($signed(p_ff[a]));
            end
            mj_in = mass_rd;
         end
         OP_SQ: r2_in = (cmd.axis == 2'd0) ? '0 : (r2_ff + R2W'(psh));
         OP_GM: r2_in = r2_ff + R2W'(psh);
         OP_ROOT_START: gm_in = mul_p_ff;
         OP_A_START: r_in = (r_raw == '0) ? 33'd1 : r_raw;
         OP_A_TAKE: a_in = (dv_q_ff > 64'(A_MAX)) ? A_MAX : dv_q_ff[30:0];
         OP_DV: v_in[cmd.axis] = sat_add(v_ff[cmd.axis], psh, d_ff[cmd.axis][32]);
         OP_MOVE: p_in[cmd.axis] = sat_add(p_ff[cmd.axis], psh, v_ff[cmd.axis][31]);
         default: begin
            p_in = p_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      v_ff     <= v_in;
      d_ff     <= d_in;
      mj_ff    <= mj_in;
      idx_ff   <= idx_in;
      dt_ff    <= dt_in;
      r2_ff    <= r2_in;
      gm_ff    <= gm_in;
      r_ff     <= r_in;
      a_ff     <= a_in;
      mul_p_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // restoring divider, one quotient bit a cycle
   assign dv_sh = {dv_rem_ff, dv_q_ff[63]};

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_busy_ff <= 1'b0;
         dv_cnt_ff  <= '0;
      end else if (dv_start) begin
         dv_busy_ff <= 1'b1;
         dv_cnt_ff  <= '0;
      end else if (dv_busy_ff) begin
         dv_cnt_ff <= dv_cnt_ff + 7'd1;
         if (dv_cnt_ff == 7'd63) begin
            dv_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dv_start) begin
         dv_q_ff   <= dv_num;
         dv_rem_ff <= '0;
         dv_den_ff <= dv_den;
      end else if (dv_busy_ff) begin
         if (dv_sh >= {1'b0, dv_den_ff}) begin
            dv_rem_ff <= dv_sh[63:0] - dv_den_ff;
            dv_q_ff   <= {dv_q_ff[62:0], 1'b1};
         end else begin
            dv_rem_ff <= dv_sh[63:0];
            dv_q_ff   <= {dv_q_ff[62:0], 1'b0};
         end
      end
   end

   // bit-by-bit square root, 32 steps
   assign rt_sum = rt_r_ff + rt_bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_busy_ff <= 1'b0;
         rt_cnt_ff  <= '0;
      end else if (cmd.op == OP_ROOT_START) begin
         rt_busy_ff <= 1'b1;
         rt_cnt_ff  <= '0;
      end else if (rt_busy_ff) begin
         rt_cnt_ff <= rt_cnt_ff + 5'd1;
         if (rt_cnt_ff == 5'd31) begin
            rt_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ROOT_START) begin
         rt_v_ff   <= rt_in;
         rt_r_ff   <= '0;
         rt_bit_ff <= 64'h4000_0000_0000_0000;
         rt_dbl_ff <= r2_hi;
      end else if (rt_busy_ff) begin
         if (rt_v_ff >= rt_sum) begin
            rt_v_ff <= rt_v_ff - rt_sum;
            rt_r_ff <= (rt_r_ff >> 1) + rt_bit_ff;
         end else begin
            rt_r_ff <= rt_r_ff >> 1;
         end
         rt_bit_ff <= rt_bit_ff >> 2;
      end
   end

   assign status.div_done   = ~dv_busy_ff;
   assign status.root_done  = ~rt_busy_ff;
   assign status.ft_small   = (req_frame_time < SMALL_TIME);
   assign status.coincident = (pos_rd == p_ff);

   assign out_index = idx_ff;
   assign out_pos   = p_ff;

endmodule

// File: hdl/nbg_ctrl.sv
// Controller: sequences loads, substeps, pair interactions, moves and results.
// Depends on nbg_pkg; drives nbg_datapath through nbg_cmd_type.
module nbg_ctrl
   import nbg_pkg::*;
#(
   parameter int MAX_BODIES = DEFAULT_MAX_BODIES,
   parameter int IW         = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1,
   parameter int NMAX       = (MAX_BODIES < 32) ? MAX_BODIES : 32,
   parameter int CW         = $clog2(NMAX + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic           req_tuser,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic           rsp_tlast,
   input  logic [CW-1:0]  n_eff,
   input  logic [4:0]     s_eff,
   input  nbg_status_type status,
   output nbg_cmd_type    cmd,
   output logic [IW-1:0]  addr
);

   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_DT_WAIT   = 5'd1;
   localparam logic [4:0] ST_RD_I      = 5'd2;
   localparam logic [4:0] ST_LD_I      = 5'd3;
   localparam logic [4:0] ST_PAIR      = 5'd4;
   localparam logic [4:0] ST_LD_J      = 5'd5;
   localparam logic [4:0] ST_SQ        = 5'd6;
   localparam logic [4:0] ST_GM        = 5'd7;
   localparam logic [4:0] ST_ROOT_GO   = 5'd8;
   localparam logic [4:0] ST_ROOT_WAIT = 5'd9;
   localparam logic [4:0] ST_A_GO      = 5'd10;
   localparam logic [4:0] ST_A_WAIT    = 5'd11;
   localparam logic [4:0] ST_A_TAKE    = 5'd12;
   localparam logic [4:0] ST_U_GO      = 5'd13;
   localparam logic [4:0] ST_U_WAIT    = 5'd14;
   localparam logic [4:0] ST_U_TAKE    = 5'd15;
   localparam logic [4:0] ST_AC        = 5'd16;
   localparam logic [4:0] ST_DV        = 5'd17;
   localparam logic [4:0] ST_WB_I      = 5'd18;
   localparam logic [4:0] ST_M_RD      = 5'd19;
   localparam logic [4:0] ST_M_LD      = 5'd20;
   localparam logic [4:0] ST_VDT       = 5'd21;
   localparam logic [4:0] ST_MOVE      = 5'd22;
   localparam logic [4:0] ST_WB_P      = 5'd23;
   localparam logic [4:0] ST_O_RD      = 5'd24;
   localparam logic [4:0] ST_O_LD      = 5'd25;
   localparam logic [4:0] ST_O_SEND    = 5'd26;

   logic [4:0]    state_ff, state_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic [4:0]    sub_ff, sub_in;
   logic [1:0]    axis_ff, axis_in;
   logic          i_last;

   assign i_last = ((i_ff + CW'(1)) == n_eff);
   assign addr   = (state_ff == ST_PAIR) ? IW'(j_ff) : IW'(i_ff);

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      sub_in     = sub_ff;
      axis_in    = axis_ff;
      cmd.op     = OP_NONE;
      cmd.axis   = axis_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tlast  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == CMD_LOAD) begin
                  cmd.op = OP_LOAD;
               end else if (!status.ft_small && n_eff != '0) begin
                  cmd.op   = OP_DT_START;
                  sub_in   = '0;
                  state_in = ST_DT_WAIT;
               end
            end
         end
         ST_DT_WAIT: begin
            if (status.div_done) begin
               cmd.op   = OP_DT_TAKE;
               i_in     = '0;
               state_in = ST_RD_I;
            end
         end
         ST_RD_I: state_in = ST_LD_I;
         ST_LD_I: begin
            cmd.op   = OP_LATCH_I;
            j_in     = '0;
            state_in = ST_PAIR;
         end
         ST_PAIR: begin
            if (j_ff == n_eff) begin
               state_in = ST_WB_I;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + CW'(1);
            end else begin
               state_in = ST_LD_J;
            end
         end
         ST_LD_J: begin
            cmd.op = OP_LATCH_J;
            if (status.coincident) begin
               j_in     = j_ff + CW'(1);
               state_in = ST_PAIR;
            end else begin
               axis_in  = 2'd0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.op = OP_SQ;
            if (axis_ff == 2'd2) begin
               state_in = ST_GM;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_GM: begin
            cmd.op   = OP_GM;
            state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            cmd.op   = OP_ROOT_START;
            state_in = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (status.root_done) begin
               state_in = ST_A_GO;
            end
         end
         ST_A_GO: begin
            cmd.op   = OP_A_START;
            state_in = ST_A_WAIT;
         end
         ST_A_WAIT: begin
            if (status.div_done) begin
               state_in = ST_A_TAKE;
            end
         end
         ST_A_TAKE: begin
            cmd.op   = OP_A_TAKE;
            axis_in  = 2'd0;
            state_in = ST_U_GO;
         end
         ST_U_GO: begin
            cmd.op   = OP_U_START;
            state_in = ST_U_WAIT;
         end
         ST_U_WAIT: begin
            if (status.div_done) begin
               state_in = ST_U_TAKE;
            end
         end
         ST_U_TAKE: begin
            cmd.op   = OP_U_TAKE;
            state_in = ST_AC;
         end
         ST_AC: begin
            cmd.op   = OP_AC;
            state_in = ST_DV;
         end
         ST_DV: begin
            cmd.op = OP_DV;
            if (axis_ff == 2'd2) begin
               j_in     = j_ff + CW'(1);
               state_in = ST_PAIR;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_U_GO;
            end
         end
         ST_WB_I: begin
            cmd.op = OP_WB_VEL;
            if (i_last) begin
               i_in     = '0;
               state_in = ST_M_RD;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = ST_RD_I;
            end
         end
         ST_M_RD: state_in = ST_M_LD;
         ST_M_LD: begin
            cmd.op   = OP_LATCH_I;
            axis_in  = 2'd0;
            state_in = ST_VDT;
         end
         ST_VDT: begin
            cmd.op   = OP_VDT;
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            cmd.op = OP_MOVE;
            if (axis_ff == 2'd2) begin
               state_in = ST_WB_P;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_VDT;
            end
         end
         ST_WB_P: begin
            cmd.op = OP_WB_POS;
            if (!i_last) begin
               i_in     = i_ff + CW'(1);
               state_in = ST_M_RD;
            end else if ((sub_ff + 5'd1) == s_eff) begin
               i_in     = '0;
               state_in = ST_O_RD;
            end else begin
               sub_in   = sub_ff + 5'd1;
               i_in     = '0;
               state_in = ST_RD_I;
            end
         end
         ST_O_RD: state_in = ST_O_LD;
         ST_O_LD: begin
            cmd.op   = OP_LATCH_I;
            state_in = ST_O_SEND;
         end
         ST_O_SEND: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = i_last;
            if (rsp_tready) begin
               if (i_last) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + CW'(1);
                  state_in = ST_O_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         sub_ff   <= '0;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         sub_ff   <= sub_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

// File: hdl/nbody_gravity_substep.sv
// Top level of the direct-sum n-body gravity block (semi-implicit Euler, signed Q fixed point).
// Depends on nbg_pkg, nbg_ram, nbg_datapath and nbg_ctrl.
//
// A load request (req_tuser low) writes one body's position, velocity and mass in the same
// cycle as it is taken. An advance request (req_tuser high) carrying a frame time below about
// 1e-4 s, or arriving while no bodies are in use, does nothing; otherwise the frame is cut into
// the configured number of substeps. Each substep walks every ordered pair of distinct bodies
// in use through one shared 32x32 multiplier, a one-bit-per-cycle 64-bit divider and a 32-step
// square root unit; four divisions and the root dominate the work of an interacting pair, while
// coincident pairs need no division or root. Each body's velocity is written back after its
// sweep, then the substep moves the positions body by body. The dt division runs once up front.
// An advance ends with one result per body in slot order, the last marked by rsp_tlast.
// Requests are not taken until all results of an advance have been delivered. Configuration
// writes on the csr port take effect at once and must only be made while the block is idle.
module nbody_gravity_substep
   import nbg_pkg::*;
#(
   parameter int MAX_BODIES    = DEFAULT_MAX_BODIES,
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // body_index[4:0], load_x[36:5], load_y[68:37], load_z[100:69], load_vx[132:101],
   // load_vy[164:133], load_vz[196:165], load_mass[228:197], frame_time[260:229], zero pad
   input  logic [263:0] req_tdata,
   // command: 0 load, 1 advance
   input  logic         req_tuser,
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_index[4:0], new_x[36:5], new_y[68:37], new_z[100:69], zero pad
   output logic [103:0] rsp_tdata,
   output logic         rsp_tlast,
   // configuration
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int IW   = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int NMAX = (MAX_BODIES < 32) ? MAX_BODIES : 32;
   localparam int CW   = $clog2(NMAX + 1);

   logic [31:0] gravity_ff, gravity_in;
   logic [4:0]  substeps_ff, substeps_in;
   logic [5:0]  body_count_ff, body_count_in;
   logic [4:0]  s_eff;
   logic [CW-1:0] n_eff;

   nbg_cmd_type    cmd;
   nbg_status_type status;
   logic [IW-1:0]  addr;
   logic [4:0]     out_index;
   logic [95:0]    out_pos;

   // configuration registers: written in place, unknown indexes dropped
   always_comb begin
      gravity_in    = gravity_ff;
      substeps_in   = substeps_ff;
      body_count_in = body_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRAVITY:    gravity_in    = csr_wdata;
            CSR_SUBSTEPS:   substeps_in   = csr_wdata[4:0];
            CSR_BODY_COUNT: body_count_in = csr_wdata[5:0];
            default:        gravity_in    = gravity_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff    <= GRAVITY_RESET;
         substeps_ff   <= SUBSTEPS_RESET;
         body_count_ff <= BODY_COUNT_RESET;
      end else begin
         gravity_ff    <= gravity_in;
         substeps_ff   <= substeps_in;
         body_count_ff <= body_count_in;
      end
   end

   // clamp substeps to 1..16 and the body count to the slots available
   assign s_eff = (substeps_ff == 5'd0) ? 5'd1 :
                  (substeps_ff > SUBSTEPS_MAX) ? SUBSTEPS_MAX : substeps_ff;
   assign n_eff = (32'(body_count_ff) > NMAX) ? CW'(NMAX) : CW'(body_count_ff);

   nbg_ctrl #(.MAX_BODIES(MAX_BODIES), .IW(IW), .NMAX(NMAX), .CW(CW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .n_eff      (n_eff),
      .s_eff      (s_eff),
      .status     (status),
      .cmd        (cmd),
      .addr       (addr)
   );

   nbg_datapath #(.MAX_BODIES(MAX_BODIES), .FRACTION_BITS(FRACTION_BITS), .IW(IW)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .addr           (addr),
      .status         (status),
      .gravity        (gravity_ff),
      .s_eff          (s_eff),
      .req_body_index (req_tdata[4:0]),
      .req_pos        (req_tdata[100:5]),
      .req_vel        (req_tdata[196:101]),
      .req_mass       (req_tdata[228:197]),
      .req_frame_time (req_tdata[260:229]),
      .out_index      (out_index),
      .out_pos        (out_pos)
   );

   // hold the result fields in the datapath registers until taken
   assign rsp_tdata = {3'b000, out_pos, out_index};

endmodule
